[rtl/cdfgs_pkg.sv]
`timescale 1ns / 1ps

package cdfgs_pkg;

  localparam int DEF_ENTRIES = 32'h1000;
  localparam int DEF_SETS    = 5;

  localparam int SET_W    = 3;
  localparam int INDEX_W  = 12;
  localparam int WORD_W   = 64;
  localparam int SAMPLE_W = 13;

  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_SAMPLE = 1'b1
  } op_t;

endpackage

[rtl/cdfgs_ram.sv]
`timescale 1ns / 1ps

module cdfgs_ram #(
  parameter int  WIDTH  = 64,
  parameter int  DEPTH  = 2,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              en,
  input  logic              we,
  input  logic [ADDR_W-1:0] addr,
  input  logic [WIDTH-1:0]  wdata,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end
      rdata <= mem[addr];
    end
  end

endmodule

[rtl/cdf_table_gaussian_sampler.sv]
`timescale 1ns / 1ps

// Channel   Handshake           Payload
// request   in_valid/in_stall   operation, set_index, entry_index, entry_value, random_value
// result    out_valid/out_stall sample
//
// One request enters per cycle while in_stall is low; each probe reads its own table
// slice through a registered memory read, then registers the 64-bit compare into the
// next probe stage. Load requests give no result.
// Reset clears the valid bits only; table contents are undefined until written.
// A held result under out_stall freezes every stage and the memory read registers.

module cdf_table_gaussian_sampler #(
  parameter int ENTRIES = cdfgs_pkg::DEF_ENTRIES,
  parameter int SETS    = cdfgs_pkg::DEF_SETS
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 operation,
  input  logic [cdfgs_pkg::SET_W-1:0]          set_index,
  input  logic [cdfgs_pkg::INDEX_W-1:0]        entry_index,
  input  logic [cdfgs_pkg::WORD_W-1:0]         entry_value,
  input  logic [cdfgs_pkg::WORD_W-1:0]         random_value,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [cdfgs_pkg::SAMPLE_W-1:0] sample
);

  localparam int PROBES = $clog2(ENTRIES);

  typedef struct packed {
    logic                              load;
    logic                              ok;
    logic [cdfgs_pkg::SET_W-1:0]       set;
    logic [PROBES-1:0]                 idx;
    logic [PROBES-1:0]                 pos;
    logic [cdfgs_pkg::WORD_W-1:0]      val;
  } item_t;

  logic  adv;
  logic  r_valid [PROBES+1];
  item_t r_item  [PROBES+1];
  logic  q_valid [PROBES];
  item_t q_item  [PROBES];
  logic  q_hit   [PROBES];

  logic [16:0]                     idx_w;
  logic                            set_ok;
  logic                            load_in;
  item_t                           in_item;
  logic [16:0]                     pos_w;
  logic [cdfgs_pkg::SAMPLE_W-1:0]  mag;
  logic [cdfgs_pkg::SAMPLE_W-1:0]  sample_next;

  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  assign idx_w   = 17'(entry_index);
  assign set_ok  = ({2'b00, set_index} < 5'(SETS));
  assign load_in = (operation == cdfgs_pkg::OP_LOAD);

  always_comb begin
    in_item      = '0;
    in_item.load = load_in;
    in_item.ok   = load_in ? (set_ok && (idx_w < 17'(ENTRIES))) : set_ok;
    in_item.set  = set_index;
    in_item.idx  = idx_w[PROBES-1:0];
    in_item.pos  = '0;
    in_item.val  = load_in ? entry_value : random_value;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid[0] <= 1'b0;
    end else if (adv) begin
      r_valid[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      r_item[0] <= in_item;
    end
  end

  for (genvar j = 0; j < PROBES; j++) begin : g_probe
    localparam int K      = PROBES - 1 - j;
    localparam int STEP   = 1 << K;
    localparam int D      = ((ENTRIES - 1) >> (K + 1)) + 1;
    localparam int DEPTH  = SETS * D;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [PROBES-1:0]            probe;
    logic [PROBES-1:0]            sel;
    logic                         hit;
    logic                         we;
    logic [ADDR_W-1:0]            addr;
    logic [cdfgs_pkg::WORD_W-1:0] rdata;
    item_t                        nxt;

    assign probe = r_item[j].pos | PROBES'(STEP);
    assign hit   = r_item[j].ok && !r_item[j].load &&
                   ({1'b0, probe} < (PROBES+1)'(ENTRIES));
    assign sel   = r_item[j].load ? r_item[j].idx : probe;
    assign addr  = ADDR_W'(int'(r_item[j].set) * D + int'(sel >> (K + 1)));
    assign we    = adv && r_valid[j] && r_item[j].load && r_item[j].ok &&
                   ((r_item[j].idx & PROBES'(2 * STEP - 1)) == PROBES'(STEP));

    cdfgs_ram #(
      .WIDTH (cdfgs_pkg::WORD_W),
      .DEPTH (DEPTH)
    ) u_ram (
      .clk   (clk),
      .en    (adv),
      .we    (we),
      .addr  (addr),
      .wdata (r_item[j].val),
      .rdata (rdata)
    );

    always_ff @(posedge clk) begin
      if (rst) begin
        q_valid[j] <= 1'b0;
      end else if (adv) begin
        q_valid[j] <= r_valid[j];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        q_item[j] <= r_item[j];
        q_hit[j]  <= hit;
      end
    end

    always_comb begin
      nxt = q_item[j];
      if (q_hit[j] && (q_item[j].val >= rdata)) begin
        nxt.pos = q_item[j].pos | PROBES'(STEP);
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        r_valid[j+1] <= 1'b0;
      end else if (adv) begin
        r_valid[j+1] <= q_valid[j];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        r_item[j+1] <= nxt;
      end
    end
  end

  assign pos_w = 17'(r_item[PROBES].pos);
  assign mag   = pos_w[cdfgs_pkg::SAMPLE_W-1:0];

  always_comb begin
    if (!r_item[PROBES].ok) begin
      sample_next = '0;
    end else if (r_item[PROBES].val[0]) begin
      sample_next = mag;
    end else begin
      sample_next = cdfgs_pkg::SAMPLE_W'(~mag + 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= r_valid[PROBES] && !r_item[PROBES].load;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sample <= $signed(sample_next);
    end
  end

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
  import cdfgs_pkg::*;

  localparam int ENTRIES      = DEF_ENTRIES;
  localparam int SETS         = DEF_SETS;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_LIMIT  = 20000;
  localparam int TAIL_CYCLES  = 40;
  localparam int BAND         = 64;
  localparam int SPINE_LEVELS = 6;
  localparam logic [WORD_W-1:0] MID = 64'h8000_0000_0000_0000;

  logic                       clk          = 1'b0;
  logic                       rst          = 1'b1;
  logic                       in_valid     = 1'b0;
  logic                       in_stall;
  logic                       operation    = 1'b0;
  logic [SET_W-1:0]           set_index    = '0;
  logic [INDEX_W-1:0]         entry_index  = '0;
  logic [WORD_W-1:0]          entry_value  = '0;
  logic [WORD_W-1:0]          random_value = '0;
  logic                       out_valid;
  logic                       out_stall    = 1'b0;
  logic signed [SAMPLE_W-1:0] sample;

  logic [WORD_W-1:0]          cdf_model [SETS][ENTRIES];
  logic signed [SAMPLE_W-1:0] expected_samples [$];

  int errors         = 0;
  int loads_sent     = 0;
  int samples_sent   = 0;
  int samples_seen   = 0;
  int stalled_offers = 0;
  int send_idle_pct  = 0;
  int stall_pct      = 0;
  int hold_requests  = 0;
  int hold_served    = 0;
  int hold_left      = 0;

  cdf_table_gaussian_sampler u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .operation    (operation),
    .set_index    (set_index),
    .entry_index  (entry_index),
    .entry_value  (entry_value),
    .random_value (random_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .sample       (sample)
  );

  always #2 clk = ~clk;

  function automatic logic [WORD_W-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  // hold every spine entry at MID so each search stays inside the low or high band
  function automatic bit is_spine(input int unsigned idx);
    for (int k = 0; k < SPINE_LEVELS; k++) begin
      if (idx == ((ENTRIES / 2) >> k) || idx == ENTRIES - ((ENTRIES / 2) >> k)) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic bit in_band(input int unsigned idx);
    return (idx >= 1 && idx < BAND) || (idx > ENTRIES - BAND);
  endfunction

  function automatic int unsigned band_index();
    if ($urandom_range(1) == 0) return $urandom_range(BAND - 1, 1);
    return $urandom_range(ENTRIES - 1, ENTRIES - BAND + 1);
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] search_sample(input int unsigned set,
                                                               input logic [WORD_W-1:0] x);
    int unsigned pos;
    int unsigned step;
    int unsigned probe;
    logic [SAMPLE_W-1:0] mag;
    if (set >= SETS) return '0;
    pos  = 0;
    step = 1;
    while (step * 2 < ENTRIES) step = step << 1;
    while (step > 0) begin
      probe = pos + step;
      if (probe < ENTRIES && x >= cdf_model[set][probe]) pos = probe;
      step = step >> 1;
    end
    mag = pos[SAMPLE_W-1:0];
    return x[0] ? mag : SAMPLE_W'(-mag);
  endfunction

  // keep ordered tables ordered: pick a value between the neighbors
  function automatic logic [WORD_W-1:0] ordered_value(input int unsigned set,
                                                      input int unsigned idx);
    logic [WORD_W-1:0] lo;
    logic [WORD_W-1:0] hi;
    logic [WORD_W-1:0] span;
    lo = (idx <= 1) ? '0 : cdf_model[set][idx-1];
    hi = (idx >= ENTRIES - 1) ? '1 : cdf_model[set][idx+1];
    if (hi < lo) return lo;
    span = hi - lo;
    if (span == '1) return rand_word();
    return lo + rand_word() % (span + 1);
  endfunction

  function automatic logic [WORD_W-1:0] search_word(input int unsigned set);
    logic [WORD_W-1:0] base;
    base = cdf_model[set][band_index()];
    case ($urandom_range(7))
      0:       return base;
      1:       return base - 1;
      2:       return base + 1;
      3:       return base ^ 1;
      4:       return '0;
      5:       return '1;
      default: return rand_word();
    endcase
  endfunction

  task automatic send_request(input op_t op, input logic [SET_W-1:0] set,
                              input logic [INDEX_W-1:0] idx, input logic [WORD_W-1:0] value,
                              input logic [WORD_W-1:0] word);
    in_valid     <= 1'b1;
    operation    <= op;
    set_index    <= set;
    entry_index  <= idx;
    entry_value  <= value;
    random_value <= word;
    do @(posedge clk); while (in_stall);
    if (op == OP_LOAD) begin
      if (set < SETS && idx < ENTRIES) cdf_model[set][idx] = value;
      loads_sent++;
    end else begin
      expected_samples.push_back(search_sample(set, word));
      samples_sent++;
    end
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  task automatic load_entry(input int unsigned set, input int unsigned idx,
                            input logic [WORD_W-1:0] value);
    send_request(OP_LOAD, SET_W'(set), INDEX_W'(idx), value, rand_word());
  endtask

  task automatic draw_sample(input int unsigned set, input logic [WORD_W-1:0] word);
    send_request(OP_SAMPLE, SET_W'(set), INDEX_W'($urandom), rand_word(), word);
  endtask

  task automatic wait_for_results();
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    while (expected_samples.size() > 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_stall   <= 1'b0;
      hold_left   <= 0;
      hold_served <= 0;
    end else if (hold_served != hold_requests) begin
      hold_served <= hold_requests;
      hold_left   <= HOLD_CYCLES;
      out_stall   <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_stall === 1'b1) stalled_offers++;
      if (out_valid === 1'b1 && !out_stall) begin
        samples_seen++;
        if (expected_samples.size() == 0) begin
          $error("sample: no result expected, actual %0d", sample);
          errors++;
        end else begin
          logic signed [SAMPLE_W-1:0] want;
          want = expected_samples.pop_front();
          if (sample !== want) begin
            $error("sample: expected %0d, actual %0d", want, sample);
            errors++;
          end
        end
      end
    end
  end

  task automatic test_fill_tables();
    logic [WORD_W-1:0] prev;
    logic [WORD_W-1:0] inc;
    logic [WORD_W-1:0] level;
    for (int s = 0; s < SETS; s++) begin
      prev  = '0;
      level = rand_word();
      for (int i = 1; i < ENTRIES; i++) begin
        if (is_spine(i)) begin
          prev = MID;
        end else if (in_band(i)) begin
          case (s)
            0: prev = {i[INDEX_W-1:0], 52'(rand_word())};
            1: prev = ($urandom_range(3) == 0) ? prev : prev + $urandom;
            2: begin
              inc  = rand_word() >> ((i < BAND) ? 11 : 5);
              prev = (prev > '1 - inc) ? '1 : prev + inc;
            end
            3: prev = level;
            default: prev = rand_word();
          endcase
        end else begin
          continue;
        end
        load_entry(s, i, prev);
      end
    end
    wait_for_results();
  endtask

  task automatic test_directed_cases();
    draw_sample(5, rand_word());
    draw_sample(6, rand_word() | 1);
    draw_sample(7, rand_word() & ~64'd1);
    load_entry(7, ENTRIES - 1, '1);
    load_entry(5, 1, '0);
    load_entry(0, 0, '1);
    draw_sample(0, 64'd0);
    draw_sample(0, 64'd1);
    draw_sample(0, '1);
    draw_sample(0, '1 - 1);
    draw_sample(0, cdf_model[0][ENTRIES/2]);
    draw_sample(0, cdf_model[0][ENTRIES/2] - 1);
    draw_sample(0, cdf_model[0][1]);
    draw_sample(1, 64'd2);
    draw_sample(2, '1);
    draw_sample(3, '0);
    draw_sample(3, cdf_model[3][1]);
    draw_sample(4, rand_word());
    draw_sample(4, rand_word());
    wait_for_results();
  endtask

  task automatic random_item();
    int unsigned pick;
    int unsigned set;
    int unsigned idx;
    pick = $urandom_range(99);
    set  = $urandom_range(SETS - 1);
    if (pick < 80) begin
      draw_sample(set, search_word(set));
    end else if (pick < 95) begin
      idx = ($urandom_range(15) == 0) ? 0 : band_index();
      load_entry(set, idx, (set < 3) ? ordered_value(set, idx) : rand_word());
    end else begin
      send_request(op_t'($urandom_range(1)), SET_W'($urandom_range(7, SETS)),
                   INDEX_W'($urandom), rand_word(), rand_word());
    end
  endtask

  task automatic test_random_traffic(input int idle, input int stall, input int count);
    send_idle_pct = idle;
    stall_pct     = stall;
    repeat (count) random_item();
    wait_for_results();
  endtask

  task automatic test_output_holdoff();
    int unsigned set;
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_requests <= hold_requests + 1;
    repeat (60) begin
      set = $urandom_range(SETS - 1);
      draw_sample(set, search_word(set));
    end
    wait_for_results();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_fill_tables();
    test_directed_cases();
    test_random_traffic(0, 0, 110);
    test_random_traffic(76, 0, 110);
    test_random_traffic(0, 76, 110);
    test_random_traffic(37, 37, 110);
    test_output_holdoff();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_samples.size() != 0) begin
      $error("sample: %0d expected results never arrived", expected_samples.size());
      errors++;
    end
    $display("%0d loads, %0d samples sent, %0d results checked, %0d stalled offers",
             loads_sent, samples_sent, samples_seen, stalled_offers);
    $display("tables: ordered, saturated, constant, unordered; bad sets; idle mixes; hold-off");
    if (errors == 0) begin
      $display("cdf_table_gaussian_sampler: match");
    end else begin
      $display("cdf_table_gaussian_sampler: mismatch");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("cdf_table_gaussian_sampler: mismatch");
    $finish;
  end

endmodule

[cdf_table_gaussian_sampler.f]
rtl/cdfgs_pkg.sv
rtl/cdfgs_ram.sv
rtl/cdf_table_gaussian_sampler.sv
tb/sv/tb_top.sv
